@@ rtl/core/fmd_pkg.sv @@
// Shared types and constants for the FMOVEM decode and transfer sequencer.
package fmd_pkg;

    localparam int FP_REGISTERS = 8;

    // Opcode word checks
    localparam logic [15:0] OPC_FLINE_MASK = 16'hF000;
    localparam logic [15:0] OPC_FLINE      = 16'hF000;
    localparam logic [15:0] OPC_CPID_MASK  = 16'h0E00;
    localparam logic [15:0] OPC_CPID       = 16'h0200;
    localparam logic [15:0] OPC_TYPE_MASK  = 16'h01C0;

    // Command word bits
    localparam logic [15:0] CMD_MOVEM     = 16'h8000;
    localparam logic [15:0] CMD_DATA_REGS = 16'h4000;
    localparam logic [15:0] CMD_DYN_LIST  = 16'h0800;
    localparam logic [15:0] CMD_TO_MEM    = 16'h2000;

    localparam logic [31:0] SEXT_HIGH  = 32'hFFFF0000;
    localparam logic [31:0] XFER_BYTES = 32'd12;

    // Effective address modes
    localparam logic [2:0] EA_IND     = 3'd2;
    localparam logic [2:0] EA_POSTINC = 3'd3;
    localparam logic [2:0] EA_PREDEC  = 3'd4;
    localparam logic [2:0] EA_DISP    = 3'd5;
    localparam logic [2:0] EA_SPECIAL = 3'd7;

    // Register field codes under the special mode
    localparam logic [2:0] EA_ABS_W   = 3'd0;
    localparam logic [2:0] EA_ABS_L   = 3'd1;
    localparam logic [2:0] EA_PC_DISP = 3'd2;

    // Instruction lengths in bytes
    localparam logic [3:0] LEN_BASE = 4'd4;
    localparam logic [3:0] LEN_EXT1 = 4'd6;
    localparam logic [3:0] LEN_EXT2 = 4'd8;

    typedef struct packed {
        logic [15:0] opcode_word;
        logic [15:0] command_word;
        logic [15:0] ext_first;
        logic [15:0] ext_second;
        logic [31:0] pc_value;
        logic [31:0] base_value;
        logic [7:0]  list_value;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic        transfer_valid;
        logic [2:0]  fp_reg;
        logic [31:0] mem_addr;
        logic        to_memory;
        logic [31:0] next_pc;
        logic [2:0]  base_reg;
        logic        base_write;
        logic [31:0] new_base;
        logic        last;
    } t_out_word;

    // Decode stage result
    typedef struct packed {
        logic        illegal;
        logic        predec;
        logic        postinc;
        logic        to_mem;
        logic [2:0]  ea_reg;
        logic [7:0]  list;
        logic [31:0] opa;
        logic [31:0] offset;
        logic [3:0]  len;
        logic [31:0] pc;
        logic [31:0] base;
    } t_dec_word;

    // Address stage result, loaded into the sequencer
    typedef struct packed {
        logic        illegal;
        logic        predec;
        logic        postinc;
        logic        to_mem;
        logic [2:0]  ea_reg;
        logic [7:0]  list;
        logic [31:0] run;
        logic [31:0] base;
        logic [31:0] next_pc;
    } t_seq_word;

endpackage

@@ rtl/core/fmd_stream_if.sv @@
// Valid/ready channel carrying one word of a given payload type.
interface fmd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/fmd_decode.sv @@
// Decode stage: instruction checks, list select and address operand select.
module fmd_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fmd_stream_if.sink            i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fmd_pkg::t_dec_word    o_dec
);
    fmd_pkg::t_dec_word n_dec;
    fmd_pkg::t_dec_word r_dec;
    logic               r_valid;
    logic               load;
    logic [15:0]        op;
    logic [15:0]        cmd;
    logic [31:0]        sext;
    logic [2:0]         mode;

    assign load       = !r_valid || i_ready;
    assign i_in.ready = load;
    assign op         = i_in.payload.opcode_word;
    assign cmd        = i_in.payload.command_word;
    assign mode       = op[5:3];
    assign sext       = {16'h0000, i_in.payload.ext_first}
                      | (i_in.payload.ext_first[15] ? fmd_pkg::SEXT_HIGH : 32'h0);

    always_comb begin
        n_dec         = '0;
        n_dec.pc      = i_in.payload.pc_value;
        n_dec.base    = i_in.payload.base_value;
        n_dec.ea_reg  = op[2:0];
        n_dec.to_mem  = (cmd & fmd_pkg::CMD_TO_MEM) != 16'h0;
        n_dec.list    = ((cmd & fmd_pkg::CMD_DYN_LIST) != 16'h0) ?
                        i_in.payload.list_value : cmd[7:0];
        n_dec.opa     = i_in.payload.base_value;
        n_dec.len     = fmd_pkg::LEN_BASE;
        case (mode)
            fmd_pkg::EA_IND: begin
            end
            fmd_pkg::EA_POSTINC: begin
                n_dec.postinc = 1'b1;
            end
            fmd_pkg::EA_PREDEC: begin
                n_dec.predec = 1'b1;
            end
            fmd_pkg::EA_DISP: begin
                n_dec.offset = sext;
                n_dec.len    = fmd_pkg::LEN_EXT1;
            end
            fmd_pkg::EA_SPECIAL: begin
                case (op[2:0])
                    fmd_pkg::EA_ABS_W: begin
                        n_dec.opa    = 32'h0;
                        n_dec.offset = sext;
                        n_dec.len    = fmd_pkg::LEN_EXT1;
                    end
                    fmd_pkg::EA_ABS_L: begin
                        n_dec.opa = {i_in.payload.ext_first, i_in.payload.ext_second};
                        n_dec.len = fmd_pkg::LEN_EXT2;
                    end
                    fmd_pkg::EA_PC_DISP: begin
                        n_dec.opa    = i_in.payload.pc_value;
                        n_dec.offset = sext;
                        n_dec.len    = fmd_pkg::LEN_EXT1;
                    end
                    default: begin
                        n_dec.illegal = 1'b1;
                    end
                endcase
            end
            default: begin
                n_dec.illegal = 1'b1;
            end
        endcase
        if ((op & fmd_pkg::OPC_FLINE_MASK) != fmd_pkg::OPC_FLINE
            || (op & fmd_pkg::OPC_CPID_MASK) != fmd_pkg::OPC_CPID
            || (op & fmd_pkg::OPC_TYPE_MASK) != 16'h0
            || (cmd & fmd_pkg::CMD_MOVEM) == 16'h0
            || (cmd & fmd_pkg::CMD_DATA_REGS) == 16'h0) begin
            n_dec.illegal = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in.valid;
        end
        if (load && i_in.valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
endmodule

@@ rtl/core/fmd_address.sv @@
// Address stage: effective address and next instruction address adders.
module fmd_address (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fmd_pkg::t_dec_word    i_dec,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fmd_pkg::t_seq_word    o_seq
);
    fmd_pkg::t_seq_word n_seq;
    fmd_pkg::t_seq_word r_seq;
    logic               r_valid;
    logic               load;
    logic [31:0]        ea;

    assign load    = !r_valid || i_ready;
    assign o_ready = load;
    assign ea      = i_dec.opa + i_dec.offset;

    always_comb begin
        n_seq         = '0;
        n_seq.illegal = i_dec.illegal;
        n_seq.predec  = i_dec.predec;
        n_seq.postinc = i_dec.postinc;
        n_seq.to_mem  = i_dec.to_mem;
        n_seq.ea_reg  = i_dec.ea_reg;
        n_seq.list    = i_dec.list;
        n_seq.base    = i_dec.base;
        n_seq.next_pc = i_dec.pc + {28'h0, i_dec.len};
        // predecrement walks down from the register itself
        n_seq.run     = i_dec.predec ? i_dec.base : ea;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
        if (load && i_valid) begin
            r_seq <= n_seq;
        end
    end

    assign o_valid = r_valid;
    assign o_seq   = r_seq;
endmodule

@@ rtl/core/fmd_sequencer.sv @@
// Transfer sequencer: one result word per cycle into the output register while o_out is not stalled.
module fmd_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fmd_pkg::t_seq_word    i_seq,
    fmd_stream_if.source          o_out
);
    fmd_pkg::t_seq_word r_cur;
    logic               r_busy;
    fmd_pkg::t_out_word r_out;
    logic               r_out_valid;
    fmd_pkg::t_out_word n_word;
    logic [7:0]         n_list;
    logic [31:0]        n_run;
    logic [7:0]         onehot;
    logic [2:0]         sel;
    logic               found;
    logic [2:0]         idx;
    logic [31:0]        run_up;
    logic [31:0]        run_dn;
    logic               out_load;
    logic               emit;
    logic               is_last;
    logic               take;

    assign out_load = !r_out_valid || o_out.ready;
    assign emit     = r_busy && out_load;
    assign run_up   = r_cur.run + fmd_pkg::XFER_BYTES;
    assign run_dn   = r_cur.run - fmd_pkg::XFER_BYTES;

    // Pick the next listed register: highest first for predecrement.
    always_comb begin
        sel   = '0;
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < fmd_pkg::FP_REGISTERS; i++) begin
            idx = r_cur.predec ? 3'(fmd_pkg::FP_REGISTERS - 1 - i) : 3'(i);
            if (!found && r_cur.list[idx]) begin
                sel   = idx;
                found = 1'b1;
            end
        end
        onehot = 8'(1) << sel;
    end

    always_comb begin
        n_word  = '0;
        n_list  = r_cur.list;
        n_run   = r_cur.run;
        is_last = 1'b1;
        if (r_cur.illegal) begin
            n_word.status = 1'b1;
            n_word.last   = 1'b1;
        end else if (!found) begin
            n_word.next_pc  = r_cur.next_pc;
            n_word.new_base = r_cur.base;
            n_word.last     = 1'b1;
        end else begin
            n_list                = r_cur.list & ~onehot;
            is_last               = (n_list == 8'h0);
            n_word.transfer_valid = 1'b1;
            n_word.fp_reg         = sel;
            n_word.to_memory      = r_cur.to_mem;
            n_word.next_pc        = r_cur.next_pc;
            n_word.last           = is_last;
            if (r_cur.predec) begin
                n_run           = run_dn;
                n_word.mem_addr = run_dn;
                n_word.new_base = run_dn;
            end else begin
                n_run           = run_up;
                n_word.mem_addr = r_cur.run;
                n_word.new_base = r_cur.postinc ? run_up : r_cur.base;
            end
            if (r_cur.predec || r_cur.postinc) begin
                n_word.base_reg   = r_cur.ea_reg;
                n_word.base_write = 1'b1;
            end
        end
    end

    // Load the next instruction when idle or on the cycle the current one sends its last word.
    assign take    = !r_busy || (emit && is_last);
    assign o_ready = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= i_valid;
            end
            if (out_load) begin
                r_out_valid <= r_busy;
            end
        end
        if (take && i_valid) begin
            r_cur <= i_seq;
        end else if (emit) begin
            r_cur.list <= n_list;
            r_cur.run  <= n_run;
        end
        if (emit) begin
            r_out <= n_word;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;
endmodule

@@ rtl/core/fpu_fmovem_decode_sequencer.sv @@
// Top level of the FMOVEM decode and transfer sequencer.
// Path: the first result word reaches o_out through the decode, address,
//   sequencer and output registers, which load in that order.
// Throughput: the sequencer sends one result word per cycle while o_out is not
//   stalled, one per listed register (up to 8) or one if none or illegal.
// Reset: synchronous active-low i_rst_n empties every stage; payload is kept.
module fpu_fmovem_decode_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fmd_stream_if.sink    i_in,
    fmd_stream_if.source  o_out
);
    // Decode -> address stage
    logic               dec_valid;
    logic               dec_ready;
    fmd_pkg::t_dec_word dec_word;

    // Address stage -> sequencer
    logic               seq_valid;
    logic               seq_ready;
    fmd_pkg::t_seq_word seq_word;

    // Check the opcode and command, pick the list and address operands.
    fmd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_dec   (dec_word)
    );

    // Form the running transfer address (the register itself for predecrement) and the next PC.
    fmd_address u_address (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec_word),
        .o_valid (seq_valid),
        .i_ready (seq_ready),
        .o_seq   (seq_word)
    );

    // Walk the register list, one result word per cycle while o_out is not stalled,
    // through the output register; a stalled word holds the stages behind it.
    fmd_sequencer u_sequencer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seq_valid),
        .o_ready (seq_ready),
        .i_seq   (seq_word),
        .o_out   (o_out)
    );

    // An illegal instruction gives one bare final word.
    a_illegal_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.status |->
            o_out.payload.last && !o_out.payload.transfer_valid
            && o_out.payload.next_pc == 32'h0 && !o_out.payload.base_write)
        else $error("illegal word carries transfer fields");

    // Write-back only comes with a transfer.
    a_wb_on_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.base_write |-> o_out.payload.transfer_valid)
        else $error("base write without transfer");

    // A new instruction only enters the sequencer when it is free or sending its last word.
    a_seq_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_valid && seq_ready && u_sequencer.r_busy |->
            u_sequencer.emit && u_sequencer.is_last)
        else $error("sequencer loaded while words remain");
endmodule
